// ----- hw/rtl/trle_pkg.sv -----
// Shared constants for the transparent run-length encoder.
package trle_pkg;

    // Default width of the byte offset into the encoded buffer
    localparam int OFFSET_BITS_DEF = 20;

    // Depth of the write-group queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // One pixel causes at most this many byte writes
    localparam int MAX_WRITES = 4;

    // Width of a write count (0..MAX_WRITES)
    localparam int CNT_W = 3;

    // Width of a slot index within one write group
    localparam int SLOT_IDX_W = 2;

    // Run length limit and the row-end / skip marker
    localparam logic [6:0] RUN_MAX = 7'h7f;
    localparam logic [7:0] ROW_END = 8'h80;

endpackage

// ----- hw/rtl/trle_front.sv -----
// Front stage: classifies each pixel, tracks run state and builds its group of writes.
module trle_front import trle_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [7:0]                i_pixel,
    input  logic                      i_row_last,
    input  logic                      i_frame_first,
    // toward the queue
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output logic [CNT_W+MAX_WRITES*(OFFSET_BITS+9)-1:0] o_q_data
);

    localparam int SLOT_W  = OFFSET_BITS + 9;
    localparam int ENTRY_W = CNT_W + MAX_WRITES * SLOT_W;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    // Run state
    logic [OFFSET_BITS-1:0] r_wpos, n_wpos;
    logic [OFFSET_BITS-1:0] r_hpos, n_hpos;
    logic                   r_lit,  n_lit;
    logic [6:0]             r_len,  n_len;
    logic                   r_ovf,  n_ovf;

    // State as seen by this pixel (frame start clears it first)
    logic [OFFSET_BITS-1:0] s_wpos;
    logic [OFFSET_BITS-1:0] s_hpos;
    logic                   s_lit;
    logic [6:0]             s_len;
    logic                   s_ovf;

    // Saturated positions for the k-th position taken by this pixel
    logic [OFFSET_BITS-1:0] pos [MAX_WRITES+1];
    logic                   hit [MAX_WRITES+1];

    // Write group being built
    logic [OFFSET_BITS-1:0] w_off [MAX_WRITES];
    logic [7:0]             w_val [MAX_WRITES];
    logic                   w_flg [MAX_WRITES];
    logic [CNT_W-1:0]       nw;

    logic accept;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    assign s_wpos = i_frame_first ? '0 : r_wpos;
    assign s_hpos = i_frame_first ? '0 : r_hpos;
    assign s_lit  = i_frame_first ? 1'b0 : r_lit;
    assign s_len  = i_frame_first ? 7'd0 : r_len;
    assign s_ovf  = i_frame_first ? 1'b0 : r_ovf;

    // Position candidates: p+k, clamped to the last buffer byte
    always_comb begin
        logic [OFFSET_BITS:0] sum;
        for (int k = 0; k <= MAX_WRITES; k++) begin
            sum    = {1'b0, s_wpos} + (OFFSET_BITS+1)'(k);
            hit[k] = (sum >= {1'b0, OFF_MAX});
            pos[k] = hit[k] ? OFF_MAX : sum[OFFSET_BITS-1:0];
        end
    end

    // Run classification and write generation
    always_comb begin
        logic [CNT_W-1:0] nt;
        logic             ovf;
        logic             lit;
        logic [6:0]       len;
        logic [OFFSET_BITS-1:0] hpos;
        nt  = '0;
        nw  = '0;
        ovf = s_ovf;
        lit = s_lit;
        len = s_len;
        hpos = s_hpos;
        for (int j = 0; j < MAX_WRITES; j++) begin
            w_off[j] = '0;
            w_val[j] = '0;
            w_flg[j] = 1'b0;
        end

        if (i_pixel != 8'd0) begin
            // close an open skip run
            if (len != 7'd0 && !lit) begin
                w_off[nw[SLOT_IDX_W-1:0]] = pos[nt];
                w_val[nw[SLOT_IDX_W-1:0]] = ROW_END | {1'b0, len};
                w_flg[nw[SLOT_IDX_W-1:0]] = ovf;
                ovf = ovf | hit[nt];
                nt  = nt + 3'd1;
                nw  = nw + 3'd1;
                len = 7'd0;
            end
            // open a literal run: reserve its count slot
            if (len == 7'd0) begin
                hpos = pos[nt];
                ovf  = ovf | hit[nt];
                nt   = nt + 3'd1;
                lit  = 1'b1;
            end
            // the pixel itself
            w_off[nw[SLOT_IDX_W-1:0]] = pos[nt];
            w_val[nw[SLOT_IDX_W-1:0]] = i_pixel;
            w_flg[nw[SLOT_IDX_W-1:0]] = ovf;
            ovf = ovf | hit[nt];
            nt  = nt + 3'd1;
            nw  = nw + 3'd1;
            len = len + 7'd1;
            // full run or row end: patch the count slot
            if (len == RUN_MAX || i_row_last) begin
                w_off[nw[SLOT_IDX_W-1:0]] = hpos;
                w_val[nw[SLOT_IDX_W-1:0]] = {1'b0, len};
                w_flg[nw[SLOT_IDX_W-1:0]] = ovf;
                nw  = nw + 3'd1;
                len = 7'd0;
                lit = 1'b0;
            end
        end else begin
            // transparent pixel closes an open literal run
            if (len != 7'd0 && lit) begin
                w_off[nw[SLOT_IDX_W-1:0]] = hpos;
                w_val[nw[SLOT_IDX_W-1:0]] = {1'b0, len};
                w_flg[nw[SLOT_IDX_W-1:0]] = ovf;
                nw  = nw + 3'd1;
                len = 7'd0;
            end
            lit = 1'b0;
            len = len + 7'd1;
            if (i_row_last) begin
                // skip run at row end is dropped
                len = 7'd0;
            end else if (len == RUN_MAX) begin
                w_off[nw[SLOT_IDX_W-1:0]] = pos[nt];
                w_val[nw[SLOT_IDX_W-1:0]] = ROW_END | {1'b0, RUN_MAX};
                w_flg[nw[SLOT_IDX_W-1:0]] = ovf;
                ovf = ovf | hit[nt];
                nt  = nt + 3'd1;
                nw  = nw + 3'd1;
                len = 7'd0;
            end
        end

        // row terminator
        if (i_row_last) begin
            w_off[nw[SLOT_IDX_W-1:0]] = pos[nt];
            w_val[nw[SLOT_IDX_W-1:0]] = ROW_END;
            w_flg[nw[SLOT_IDX_W-1:0]] = ovf;
            ovf = ovf | hit[nt];
            nt  = nt + 3'd1;
            nw  = nw + 3'd1;
        end

        n_wpos = pos[nt];
        n_hpos = hpos;
        n_lit  = lit;
        n_len  = len;
        n_ovf  = ovf;
    end

    // Pack the write group for the queue
    always_comb begin
        o_q_data = '0;
        o_q_data[ENTRY_W-1 -: CNT_W] = nw;
        for (int j = 0; j < MAX_WRITES; j++) begin
            o_q_data[j*SLOT_W +: SLOT_W] = {w_off[j], w_val[j], w_flg[j]};
        end
    end

    assign o_q_push = accept && (nw != '0);

    // State update on each accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_hpos <= '0;
            r_lit  <= 1'b0;
            r_len  <= 7'd0;
            r_ovf  <= 1'b0;
        end else if (accept) begin
            r_wpos <= n_wpos;
            r_hpos <= n_hpos;
            r_lit  <= n_lit;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
        end
    end

endmodule

// ----- hw/rtl/trle_queue.sv -----
// Short queue of write groups between the front and back stages.
module trle_queue import trle_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Pointer and fill count update
    always_comb begin
        n_wr  = do_push ? ((r_wr == LAST_PTR) ? '0 : r_wr + AW'(1)) : r_wr;
        n_rd  = do_pop  ? ((r_rd == LAST_PTR) ? '0 : r_rd + AW'(1)) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/trle_back.sv -----
// Back stage: hands out the writes of the queue head one word at a time.
module trle_back import trle_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // from the queue
    input  logic [CNT_W+MAX_WRITES*(OFFSET_BITS+9)-1:0] i_q_data,
    input  logic                   i_q_empty,
    output logic                   o_q_pop,
    // result side
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [7:0]             o_value,
    output logic                   o_overflow,
    output logic                   o_last
);

    localparam int SLOT_W  = OFFSET_BITS + 9;
    localparam int ENTRY_W = CNT_W + MAX_WRITES * SLOT_W;

    logic [SLOT_IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]      cnt;
    logic [SLOT_W-1:0]     slot;
    logic                  fire;

    assign cnt  = i_q_data[ENTRY_W-1 -: CNT_W];
    assign slot = i_q_data[r_idx*SLOT_W +: SLOT_W];

    assign o_empty    = i_q_empty;
    assign o_offset   = slot[SLOT_W-1 -: OFFSET_BITS];
    assign o_value    = slot[8:1];
    assign o_overflow = slot[0];
    assign o_last     = ({1'b0, r_idx} == (cnt - CNT_W'(1)));

    assign fire    = i_pop && !i_q_empty;
    assign o_q_pop = fire && o_last;

    // Slot index within the head group
    always_comb begin
        n_idx = r_idx;
        if (fire) begin
            n_idx = o_last ? '0 : r_idx + SLOT_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

// ----- hw/rtl/transparent_run_length_encoder.sv -----
// A pixel's writes are registered in the write-group queue before they reach the result ports.
// Throughput: one pixel per cycle while each pixel causes at most one write; a pixel that
// causes several writes hands them out one per pop, and a 4-entry queue of write groups
// absorbs the bursts, so the input stalls only when that queue is full.
// Reset: synchronous, active low; clears run state, write offset, overflow and the queue.
module transparent_run_length_encoder import trle_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_pixel,
    input  logic                   i_row_last,
    input  logic                   i_frame_first,
    output logic                   empty,
    input  logic                   pop,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [7:0]             o_value,
    output logic                   o_overflow,
    output logic                   o_last
);

    localparam int ENTRY_W = CNT_W + MAX_WRITES * (OFFSET_BITS + 9);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;

    // Pixel classification and run tracking
    trle_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_pixel       (i_pixel),
        .i_row_last    (i_row_last),
        .i_frame_first (i_frame_first),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    // Write-group queue
    trle_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Write serializer
    trle_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (q_rdata),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_offset   (o_offset),
        .o_value    (o_value),
        .o_overflow (o_overflow),
        .o_last     (o_last)
    );

endmodule

// ----- test/tb_transparent_run_length_encoder.sv -----
// Self-checking testbench for the transparent run-length encoder.
module tb_transparent_run_length_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import trle_pkg::*;

    // Buffer offset width for the device under test
    localparam int OFF_W = 10;
    localparam logic [OFF_W-1:0] OFF_MAX = '1;
    localparam int TAIL_WORDS = 48;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_last;
        logic       frame_first;
        logic       sync;
    } pixel_word_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [7:0]       value;
        logic             ovf;
        logic             last;
    } write_word_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       i_pixel = 8'h00;
    logic             i_row_last = 1'b0;
    logic             i_frame_first = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [OFF_W-1:0] o_offset;
    logic [7:0]       o_value;
    logic             o_overflow;
    logic             o_last;

    pixel_word_t pixel_queue[$];
    write_word_t pending_writes[$];

    // Encoder state mirror
    logic [OFF_W-1:0] enc_pos = '0;
    logic [OFF_W-1:0] enc_hdr = '0;
    bit               enc_lit = 1'b0;
    int               enc_len = 0;
    bit               enc_ovf = 1'b0;

    int  errors = 0;
    int  pixel_count = 0;
    int  frame_count = 0;
    int  write_count = 0;
    int  ovf_writes = 0;
    int  send_gap = 0;
    int  send_calm = 0;
    int  stall_gap = 0;
    int  stall_calm = 0;
    bit  tail_phase = 1'b0;

    transparent_run_length_encoder #(
        .OFFSET_BITS(OFF_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_pixel      (i_pixel),
        .i_row_last   (i_row_last),
        .i_frame_first(i_frame_first),
        .empty        (empty),
        .pop          (pop),
        .o_offset     (o_offset),
        .o_value      (o_value),
        .o_overflow   (o_overflow),
        .o_last       (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Next free byte position, sticking at the last one and flagging overflow
    function automatic logic [OFF_W-1:0] claim_pos();
        logic [OFF_W-1:0] p;
        p = enc_pos;
        if (p == OFF_MAX) begin
            enc_ovf = 1'b1;
        end else begin
            enc_pos = p + 1'b1;
        end
        return p;
    endfunction

    task automatic new_write(ref write_word_t grp[$], input logic [7:0] v);
        logic f;
        logic [OFF_W-1:0] p;
        f = enc_ovf;
        p = claim_pos();
        grp.push_back('{offset: p, value: v, ovf: f, last: 1'b0});
    endtask

    task automatic patch_count(ref write_word_t grp[$]);
        grp.push_back('{offset: enc_hdr, value: 8'(enc_len), ovf: enc_ovf, last: 1'b0});
        enc_len = 0;
    endtask

    // Expected byte writes for one accepted pixel
    task automatic encode_pixel(input logic [7:0] pix, input logic rl, input logic ff);
        write_word_t grp[$];
        if (ff) begin
            enc_pos = '0;
            enc_hdr = '0;
            enc_lit = 1'b0;
            enc_len = 0;
            enc_ovf = 1'b0;
            frame_count++;
        end
        if (pix != 8'h00) begin
            // skip run closes when a literal starts
            if (enc_len != 0 && !enc_lit) begin
                new_write(grp, ROW_END | 8'(enc_len));
                enc_len = 0;
            end
            if (enc_len == 0) begin
                enc_hdr = claim_pos();
                enc_lit = 1'b1;
            end
            new_write(grp, pix);
            enc_len++;
            if (enc_len >= int'(RUN_MAX) || rl) begin
                patch_count(grp);
                enc_lit = 1'b0;
            end
        end else begin
            if (enc_len != 0 && enc_lit) begin
                patch_count(grp);
            end
            enc_lit = 1'b0;
            enc_len++;
            // skip run at the row end is dropped
            if (rl) begin
                enc_len = 0;
            end else if (enc_len >= int'(RUN_MAX)) begin
                new_write(grp, ROW_END | 8'(RUN_MAX));
                enc_len = 0;
            end
        end
        if (rl) begin
            new_write(grp, ROW_END);
        end
        if (grp.size() > 0) begin
            grp[grp.size()-1].last = 1'b1;
        end
        foreach (grp[k]) begin
            pending_writes.push_back(grp[k]);
        end
    endtask

    // Random idle bursts with quiet stretches; none near the end
    function automatic int idle_burst(inout int calm);
        if (tail_phase) begin
            return 0;
        end
        if (calm > 0) begin
            calm--;
            return 0;
        end
        case ($urandom_range(0, 19))
            0, 1: return $urandom_range(1, 16);
            2: begin
                calm = $urandom_range(30, 80);
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    // Input side: load words from the pixel queue
    always @(posedge i_clk) begin
        pixel_word_t w;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                encode_pixel(i_pixel, i_row_last, i_frame_first);
                pixel_count++;
            end
            if (push && full) begin
                // word still waiting
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (pixel_queue.size() == 0 ||
                         (pixel_queue[0].sync && pending_writes.size() != 0)) begin
                push <= 1'b0;
            end else begin
                w = pixel_queue.pop_front();
                i_pixel <= w.pixel;
                i_row_last <= w.row_last;
                i_frame_first <= w.frame_first;
                push <= 1'b1;
                send_gap = idle_burst(send_calm);
            end
            tail_phase <= (pixel_queue.size() < TAIL_WORDS);
        end
    end

    // Output side: compare each popped word with the oldest expected write
    always @(posedge i_clk) begin
        write_word_t e;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                write_count++;
                if (o_overflow) begin
                    ovf_writes++;
                end
                if (pending_writes.size() == 0) begin
                    $display("%0t ns: unexpected write, expected none, actual offset 0x%0h value 0x%0h",
                             $time, o_offset, o_value);
                    errors++;
                end else begin
                    e = pending_writes.pop_front();
                    check_field("offset", 32'(e.offset), 32'(o_offset));
                    check_field("value", 32'(e.value), 32'(o_value));
                    check_field("overflow", 32'(e.ovf), 32'(o_overflow));
                    check_field("last", 32'(e.last), 32'(o_last));
                end
            end
            if (stall_gap > 0) begin
                stall_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                stall_gap = idle_burst(stall_calm);
            end
        end
    end

    task automatic add_pixel(input logic [7:0] pix, input bit rl, input bit ff,
                             input bit sync = 1'b0);
        pixel_queue.push_back('{pixel: pix, row_last: rl, frame_first: ff, sync: sync});
    endtask

    task automatic add_run(input bit lit, input int len, input bit end_row, input bit ff);
        for (int k = 0; k < len; k++) begin
            add_pixel(lit ? 8'($urandom_range(1, 255)) : 8'h00,
                      end_row && k == len - 1, ff && k == 0);
        end
    endtask

    // Well-formed row: a few short runs
    task automatic add_random_row(input bit ff);
        int nruns;
        int len;
        bit lit;
        nruns = $urandom_range(1, 4);
        for (int r = 0; r < nruns; r++) begin
            lit = $urandom_range(0, 1);
            case ($urandom_range(0, 19))
                0, 1, 2: len = $urandom_range(7, 12);
                default: len = $urandom_range(1, 6);
            endcase
            add_run(lit, len, r == nruns - 1, ff && r == 0);
        end
    endtask

    task automatic add_noise(input int cnt);
        for (int k = 0; k < cnt; k++) begin
            add_pixel($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)),
                      $urandom_range(0, 7) == 0, $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin
        int base;

        // Directed: field extremes, run switches, dropped skips, abandoned run
        add_pixel(8'hFF, 0, 1);
        add_pixel(8'h01, 0, 0);
        add_pixel(8'h00, 0, 0);
        add_pixel(8'h00, 0, 0);
        add_pixel(8'h80, 0, 0);
        add_pixel(8'h7F, 1, 0);
        add_pixel(8'h00, 1, 0);
        add_pixel(8'h00, 0, 0);
        add_pixel(8'h00, 0, 0);
        add_pixel(8'h00, 1, 0);
        add_pixel(8'h55, 1, 0);
        add_pixel(8'h00, 0, 0);
        add_pixel(8'hAA, 1, 0);
        add_pixel(8'h33, 0, 0);
        add_pixel(8'h00, 0, 0);
        add_pixel(8'h00, 1, 0);
        add_pixel(8'h12, 0, 0);
        add_pixel(8'h34, 0, 1);
        add_pixel(8'h00, 0, 1);
        add_pixel(8'h00, 1, 0);
        add_pixel(8'hFE, 1, 1);

        // Run limits: full literal run, full skip run, then a four-write pixel
        base = pixel_queue.size();
        add_run(1, 128, 0, 1);
        pixel_queue[base].sync = 1'b1;
        add_run(0, 2, 1, 0);
        add_run(0, 128, 0, 0);
        add_run(1, 1, 1, 0);

        // Random rows and frames with some malformed words mixed in
        base = pixel_queue.size();
        add_random_row(1);
        pixel_queue[base].sync = 1'b1;
        while (pixel_queue.size() - base < 20) begin
            if ($urandom_range(0, 6) == 0) begin
                add_noise($urandom_range(2, 10));
            end else begin
                add_random_row($urandom_range(0, 5) == 0);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || push || pending_writes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Run: %0d pixels over %0d frames, %0d writes checked, %0d flagged overflow",
                 pixel_count, frame_count, write_count, ovf_writes);
        $display("Covered run limits on literal and skip runs, dropped row-end skips and abandoned runs");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(10_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
